/* rtl/pimrp_pkg.sv */
// Package for the point-in-mesh ray parity block: request types, controller and
// datapath command/status structs, and the multiply-accumulate microcode table.
// No dependencies.
package pimrp_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CROSS_W         = 16;
    localparam int COORD_W         = 32;
    localparam int DIFF_W          = COORD_W + 1;      // exact vertex difference
    localparam int MOP_W           = 35;               // multiplier operand width
    localparam int PROD_W          = 2 * MOP_W;        // product width
    localparam int CROSS_PROD_W    = 67;               // a, U, V, qy, qz exact width
    localparam int ACC_W           = 104;              // T exact width with headroom
    localparam int LO_W            = 34;               // low split of a 67 bit operand
    localparam int NUM_STEPS       = 16;
    localparam int STEP_W          = 4;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TRI   = 1'b1;

    // Multiplier operand selects.
    localparam logic [3:0] SEL_E1X  = 4'd0;
    localparam logic [3:0] SEL_E1Y  = 4'd1;
    localparam logic [3:0] SEL_E1Z  = 4'd2;
    localparam logic [3:0] SEL_E2X  = 4'd3;
    localparam logic [3:0] SEL_E2Y  = 4'd4;
    localparam logic [3:0] SEL_E2Z  = 4'd5;
    localparam logic [3:0] SEL_SX   = 4'd6;
    localparam logic [3:0] SEL_SY   = 4'd7;
    localparam logic [3:0] SEL_SZ   = 4'd8;
    localparam logic [3:0] SEL_VLO  = 4'd9;
    localparam logic [3:0] SEL_VHI  = 4'd10;
    localparam logic [3:0] SEL_QYLO = 4'd11;
    localparam logic [3:0] SEL_QYHI = 4'd12;
    localparam logic [3:0] SEL_QZLO = 4'd13;
    localparam logic [3:0] SEL_QZHI = 4'd14;

    // Accumulator destinations.
    localparam logic [2:0] DST_NONE = 3'd0;
    localparam logic [2:0] DST_A    = 3'd1;
    localparam logic [2:0] DST_U    = 3'd2;
    localparam logic [2:0] DST_V    = 3'd3;
    localparam logic [2:0] DST_QY   = 3'd4;
    localparam logic [2:0] DST_QZ   = 3'd5;
    localparam logic [2:0] DST_T    = 3'd6;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] p0_x;
        logic signed [31:0] p0_y;
        logic signed [31:0] p0_z;
        logic signed [31:0] p1_x;
        logic signed [31:0] p1_y;
        logic signed [31:0] p1_z;
        logic signed [31:0] p2_x;
        logic signed [31:0] p2_y;
        logic signed [31:0] p2_z;
        logic               last;
    } t_in_req;

    typedef struct packed {
        logic        inside_res;
        logic [15:0] crossings;
    } t_out_req;

    typedef struct packed {
        logic [3:0] sel_a;
        logic [3:0] sel_b;
        logic       sub;
        logic       shift_hi;
        logic [2:0] dst;
    } t_uop;

    typedef struct packed {
        logic              capture;
        logic              diff;
        logic              issue;
        logic [STEP_W-1:0] issue_step;
        logic              accum;
        logic [STEP_W-1:0] accum_step;
        logic              decide;
        logic              emit;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_sts;

    // One entry per product term of a, U, V, qy and qz, and two per term of T (low and high half).
    function automatic t_uop ucode(input logic [STEP_W-1:0] step);
        t_uop u;
        u = '{SEL_E1X, SEL_E1X, 1'b0, 1'b0, DST_NONE};
        case (step)
            4'd0:  u = '{SEL_E2Y, SEL_E1Z,  1'b0, 1'b0, DST_NONE};
            4'd1:  u = '{SEL_E2Z, SEL_E1Y,  1'b1, 1'b0, DST_A};
            4'd2:  u = '{SEL_E2Y, SEL_SZ,   1'b0, 1'b0, DST_NONE};
            4'd3:  u = '{SEL_E2Z, SEL_SY,   1'b1, 1'b0, DST_U};
            4'd4:  u = '{SEL_SY,  SEL_E1Z,  1'b0, 1'b0, DST_NONE};
            4'd5:  u = '{SEL_SZ,  SEL_E1Y,  1'b1, 1'b0, DST_V};
            4'd6:  u = '{SEL_SZ,  SEL_E1X,  1'b0, 1'b0, DST_NONE};
            4'd7:  u = '{SEL_SX,  SEL_E1Z,  1'b1, 1'b0, DST_QY};
            4'd8:  u = '{SEL_SX,  SEL_E1Y,  1'b0, 1'b0, DST_NONE};
            4'd9:  u = '{SEL_SY,  SEL_E1X,  1'b1, 1'b0, DST_QZ};
            4'd10: u = '{SEL_E2X, SEL_VLO,  1'b0, 1'b0, DST_NONE};
            4'd11: u = '{SEL_E2X, SEL_VHI,  1'b0, 1'b1, DST_NONE};
            4'd12: u = '{SEL_E2Y, SEL_QYLO, 1'b0, 1'b0, DST_NONE};
            4'd13: u = '{SEL_E2Y, SEL_QYHI, 1'b0, 1'b1, DST_NONE};
            4'd14: u = '{SEL_E2Z, SEL_QZLO, 1'b0, 1'b0, DST_NONE};
            4'd15: u = '{SEL_E2Z, SEL_QZHI, 1'b0, 1'b1, DST_T};
            default: u = '{SEL_E1X, SEL_E1X, 1'b0, 1'b0, DST_NONE};
        endcase
        return u;
    endfunction

endpackage

/* rtl/pimrp_if.sv */
// Valid/ready channel interfaces for the input and result requests.
// Depends on pimrp_pkg.
interface pimrp_in_if;
    logic               valid;
    logic               ready;
    pimrp_pkg::t_in_req req;
    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface

interface pimrp_out_if;
    logic                valid;
    logic                ready;
    pimrp_pkg::t_out_req req;
    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface

/* rtl/pimrp_ctrl.sv */
// Controller state machine: sequences capture, differencing, the sixteen
// multiply-accumulate steps, the crossing decision and the result hand-off.
// Depends on pimrp_pkg.
module pimrp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_operation,
    input  logic              i_last,
    output logic              o_ready,
    input  pimrp_pkg::t_sts   i_sts,
    output pimrp_pkg::t_cmd   o_cmd
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIFF   = 3'd1;
    localparam logic [2:0] S_RUN    = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;
    localparam int CNT_W = pimrp_pkg::STEP_W + 1;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_last, n_last;
    logic             accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_last  = r_last;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    n_last        = i_last;
                    if (i_operation == pimrp_pkg::OP_START) begin
                        n_state = i_last ? S_EMIT : S_IDLE;
                    end else begin
                        n_state = S_DIFF;
                    end
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_cnt      = '0;
                n_state    = S_RUN;
            end
            S_RUN: begin
                o_cmd.issue      = (r_cnt < CNT_W'(pimrp_pkg::NUM_STEPS));
                o_cmd.issue_step = r_cnt[pimrp_pkg::STEP_W-1:0];
                o_cmd.accum      = (r_cnt != '0);
                o_cmd.accum_step = r_cnt[pimrp_pkg::STEP_W-1:0] - 1'b1;
                n_cnt            = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(pimrp_pkg::NUM_STEPS)) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = r_last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
        end
    end
endmodule

/* rtl/pimrp_dp.sv */
// Datapath: query point, vertex and edge registers, one shared multiplier with
// a registered product, the exact accumulator, crossing decision, count and
// the result register. Depends on pimrp_pkg.
module pimrp_dp #(
    parameter int COUNT_WIDTH = pimrp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pimrp_pkg::t_in_req  i_req,
    input  pimrp_pkg::t_cmd     i_cmd,
    output pimrp_pkg::t_sts     o_sts,
    output logic                o_valid,
    input  logic                i_ready,
    output pimrp_pkg::t_out_req o_req
);
    localparam int DW = pimrp_pkg::DIFF_W;
    localparam int MW = pimrp_pkg::MOP_W;
    localparam int CW = pimrp_pkg::CROSS_PROD_W;
    localparam int AW = pimrp_pkg::ACC_W;
    localparam int LW = pimrp_pkg::LO_W;
    localparam int PW = pimrp_pkg::PROD_W;
    localparam int DEC_W = CW + 2;

    logic signed [31:0]   r_qx, r_qy, r_qz;
    pimrp_pkg::t_in_req   r_tri;
    logic signed [DW-1:0] r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z, r_sx, r_sy, r_sz;
    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_acc, n_acc, term;
    logic signed [CW-1:0] r_a, r_u, r_v, r_qyv, r_qzv;
    logic signed [AW-1:0] r_t;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                 r_parity;
    logic                 r_ovalid;
    pimrp_pkg::t_out_req  r_oreq;
    pimrp_pkg::t_uop      uop_i, uop_a;
    logic signed [MW-1:0] opa, opb;
    logic signed [DEC_W-1:0] a_n, u_n, v_n, a_u, a_uv;
    logic signed [AW-1:0] t_n;
    logic                 hit;
    logic [31:0]          count32;

    function automatic logic signed [MW-1:0] pick(
        input logic [3:0] sel,
        input logic signed [DW-1:0] e1x, e1y, e1z, e2x, e2y, e2z, sx, sy, sz,
        input logic signed [CW-1:0] v, qy, qz
    );
        logic signed [MW-1:0] r;
        r = '0;
        case (sel)
            pimrp_pkg::SEL_E1X:  r = MW'(e1x);
            pimrp_pkg::SEL_E1Y:  r = MW'(e1y);
            pimrp_pkg::SEL_E1Z:  r = MW'(e1z);
            pimrp_pkg::SEL_E2X:  r = MW'(e2x);
            pimrp_pkg::SEL_E2Y:  r = MW'(e2y);
            pimrp_pkg::SEL_E2Z:  r = MW'(e2z);
            pimrp_pkg::SEL_SX:   r = MW'(sx);
            pimrp_pkg::SEL_SY:   r = MW'(sy);
            pimrp_pkg::SEL_SZ:   r = MW'(sz);
            pimrp_pkg::SEL_VLO:  r = {{(MW-LW){1'b0}}, v[LW-1:0]};
            pimrp_pkg::SEL_VHI:  r = MW'($signed(v[CW-1:LW]));
            pimrp_pkg::SEL_QYLO: r = {{(MW-LW){1'b0}}, qy[LW-1:0]};
            pimrp_pkg::SEL_QYHI: r = MW'($signed(qy[CW-1:LW]));
            pimrp_pkg::SEL_QZLO: r = {{(MW-LW){1'b0}}, qz[LW-1:0]};
            pimrp_pkg::SEL_QZHI: r = MW'($signed(qz[CW-1:LW]));
            default:             r = '0;
        endcase
        return r;
    endfunction

    assign uop_i = pimrp_pkg::ucode(i_cmd.issue_step);
    assign uop_a = pimrp_pkg::ucode(i_cmd.accum_step);
    assign opa   = pick(uop_i.sel_a, r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z,
                        r_sx, r_sy, r_sz, r_v, r_qyv, r_qzv);
    assign opb   = pick(uop_i.sel_b, r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z,
                        r_sx, r_sy, r_sz, r_v, r_qyv, r_qzv);

    // High halves of the split operands carry weight 2^34.
    always_comb begin
        term = uop_a.shift_hi ? (AW'(r_prod) <<< LW) : AW'(r_prod);
        if (uop_a.sub) begin
            term = -term;
        end
        n_acc = r_acc + term;
    end

    // Crossing decision with everything multiplied through by the sign of a.
    always_comb begin
        a_n  = r_a[CW-1] ? -DEC_W'(r_a) : DEC_W'(r_a);
        u_n  = r_a[CW-1] ? -DEC_W'(r_u) : DEC_W'(r_u);
        v_n  = r_a[CW-1] ? -DEC_W'(r_v) : DEC_W'(r_v);
        t_n  = r_a[CW-1] ? -r_t : r_t;
        a_u  = a_n - u_n;
        a_uv = a_n - u_n - v_n;
        hit  = (r_a != '0) && !u_n[DEC_W-1] && !a_u[DEC_W-1] && !v_n[DEC_W-1]
               && !a_uv[DEC_W-1] && !t_n[AW-1] && (t_n != '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_tri <= i_req;
        end
        if (i_cmd.diff) begin
            r_e1x <= DW'(r_tri.p1_x) - DW'(r_tri.p0_x);
            r_e1y <= DW'(r_tri.p1_y) - DW'(r_tri.p0_y);
            r_e1z <= DW'(r_tri.p1_z) - DW'(r_tri.p0_z);
            r_e2x <= DW'(r_tri.p2_x) - DW'(r_tri.p0_x);
            r_e2y <= DW'(r_tri.p2_y) - DW'(r_tri.p0_y);
            r_e2z <= DW'(r_tri.p2_z) - DW'(r_tri.p0_z);
            r_sx  <= DW'(r_qx) - DW'(r_tri.p0_x);
            r_sy  <= DW'(r_qy) - DW'(r_tri.p0_y);
            r_sz  <= DW'(r_qz) - DW'(r_tri.p0_z);
            r_acc <= '0;
        end
        if (i_cmd.issue) begin
            r_prod <= opa * opb;
        end
        if (i_cmd.accum) begin
            if (uop_a.dst == pimrp_pkg::DST_NONE) begin
                r_acc <= n_acc;
            end else begin
                r_acc <= '0;
            end
            case (uop_a.dst)
                pimrp_pkg::DST_A:  r_a   <= n_acc[CW-1:0];
                pimrp_pkg::DST_U:  r_u   <= n_acc[CW-1:0];
                pimrp_pkg::DST_V:  r_v   <= n_acc[CW-1:0];
                pimrp_pkg::DST_QY: r_qyv <= n_acc[CW-1:0];
                pimrp_pkg::DST_QZ: r_qzv <= n_acc[CW-1:0];
                pimrp_pkg::DST_T:  r_t   <= n_acc;
                default: ;
            endcase
        end
        if (i_cmd.emit) begin
            r_oreq <= '{r_parity, (count32 > 32'hFFFF) ? 16'hFFFF : count32[15:0]};
        end
    end

    assign count32 = 32'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx     <= '0;
            r_qy     <= '0;
            r_qz     <= '0;
            r_count  <= '0;
            r_parity <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.capture && i_req.operation == pimrp_pkg::OP_START) begin
                r_qx     <= i_req.p0_x;
                r_qy     <= i_req.p0_y;
                r_qz     <= i_req.p0_z;
                r_count  <= '0;
                r_parity <= 1'b0;
            end else if (i_cmd.decide && hit) begin
                if (r_count != '1) begin
                    r_count <= r_count + 1'b1;
                end
                r_parity <= !r_parity;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_sts.out_busy = r_ovalid && !i_ready;
    assign o_valid        = r_ovalid;
    assign o_req          = r_oreq;
endmodule

/* rtl/point_in_mesh_ray_parity.sv */
// Point-in-mesh test by +X ray crossing parity, one triangle request at a time.
// A start request is handled in the accepting state; a triangle request passes
// through it, a differencing step, sixteen products through the single shared
// multiplier plus a final accumulate, and a decision step. A last request also
// loads the result register, waiting while an earlier result still waits.
// Synchronous active-low reset clears the query point, count, parity and valid.
module point_in_mesh_ray_parity #(
    parameter int COUNT_WIDTH = pimrp_pkg::COUNT_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pimrp_in_if.sink           i_in,
    pimrp_out_if.source        o_out
);
    // The controller walks IDLE, DIFF, RUN, DECIDE and EMIT. The datapath holds
    // all arithmetic; the two exchange only the command and status structs.
    // The result register decouples the output side: the block goes back to
    // accepting requests as soon as a result is loaded, even while it waits.
    pimrp_pkg::t_cmd cmd;
    pimrp_pkg::t_sts sts;

    pimrp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .i_operation (i_in.req.operation),
        .i_last      (i_in.req.last),
        .o_ready     (i_in.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Every cross product is carried exactly, so the sign tests need no rounding.
    pimrp_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_in.req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_req   (o_out.req)
    );
endmodule

/* rtl/pimrp_checker.sv */
// Port-level checker for the point-in-mesh block, attached by bind.
// Depends on pimrp_pkg and the top level.
module pimrp_checker #(
    parameter int COUNT_WIDTH = pimrp_pkg::COUNT_WIDTH_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_op,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_inside,
    input logic [15:0] i_crossings
);
    localparam int SAT_W = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;
    localparam logic [16:0] SAT = (17'd1 << SAT_W) - 17'd1;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (17'(i_crossings) != SAT) |-> i_inside == i_crossings[0])
        else $error("inside flag disagrees with crossing count");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_tri_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_op |=> !$rose(i_out_valid))
        else $error("result too soon after triangle request");
endmodule

bind point_in_mesh_ray_parity pimrp_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_pimrp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.req.operation),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_inside    (o_out.req.inside_res),
    .i_crossings (o_out.req.crossings)
);
